// ===== rtl/can_register_node_handler_macros.svh =====
// ============================================================================
// CAN register node handler assertion macros
// Shared concurrent assertion forms used by the RTL of the node handler.
// ============================================================================
`ifndef CAN_REGISTER_NODE_HANDLER_MACROS_SVH
`define CAN_REGISTER_NODE_HANDLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CNH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("node handler check failed");

// The consequent must hold in the cycle after the antecedent.
`define CNH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("node handler check failed");

`endif

// ===== rtl/cnh_pkg.sv =====
// ============================================================================
// CAN register node handler package
// Widths, protocol constants, register indexes and shared types.
// ============================================================================
package cnh_pkg;

    localparam int ID_W      = 29;
    localparam int REG_W     = 11;
    localparam int NODE_W    = 16;
    localparam int LEN_W     = 4;
    localparam int DATA_W    = 64;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam int ID_NODE_LSB = 11;
    localparam int ID_NODE_MSB = 26;
    localparam int ID_ACK_BIT  = 27;
    localparam int ID_PRIO_BIT = 28;

    localparam logic [NODE_W-1:0] BCAST_NODE    = 16'hFFFF;
    localparam logic [REG_W-1:0]  REG_DEVICE_ID = 11'h000;
    localparam logic [7:0]        PROTO_VERSION = 8'h08;
    localparam logic [LEN_W-1:0]  REPLY_LEN     = 4'd8;
    localparam logic [LEN_W-1:0]  ACK_LEN       = 4'd0;
    localparam logic [LEN_W-1:0]  MIN_WRITE_LEN = 4'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SHORT     = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BCAST_REF = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_TYPE      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPGRADE_CAPS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRMWARE_VERSION = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   frame_id;
        logic              remote_request;
        logic [LEN_W-1:0]  payload_len;
        logic [DATA_W-1:0] payload;
    } cnh_frame_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                to_application;
        logic [REG_W-1:0]    op_register;
        logic                op_priority;
        logic                op_ack;
        logic                op_broadcast;
        logic                op_remote;
        logic                send_valid;
        logic [ID_W-1:0]     send_id;
        logic [LEN_W-1:0]    out_len;
        logic [DATA_W-1:0]   out_payload;
    } cnh_result_t;

    typedef struct packed {
        logic [NODE_W-1:0] node_address;
        logic [7:0]        device_type;
        logic [7:0]        upgrade_caps;
        logic [15:0]       firmware_version;
    } cnh_cfg_t;

    typedef struct packed {
        logic              load;
        logic [NODE_W-1:0] addr;
    } cnh_addr_upd_t;

endpackage

// ===== rtl/cnh_ifs.sv =====
// ============================================================================
// CAN register node handler channels
// Valid/ready channels for received frames and handler results.
// ============================================================================
interface cnh_frame_if;
    import cnh_pkg::*;

    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic              remote_request;
    logic [LEN_W-1:0]  payload_len;
    logic [DATA_W-1:0] payload;

    modport source (output valid, frame_id, remote_request, payload_len, payload,
                    input ready);
    modport sink   (input valid, frame_id, remote_request, payload_len, payload,
                    output ready);
endinterface

interface cnh_result_if;
    import cnh_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                to_application;
    logic [REG_W-1:0]    op_register;
    logic                op_priority;
    logic                op_ack;
    logic                op_broadcast;
    logic                op_remote;
    logic                send_valid;
    logic [ID_W-1:0]     send_id;
    logic [LEN_W-1:0]    out_len;
    logic [DATA_W-1:0]   out_payload;

    modport source (output valid, status, to_application, op_register, op_priority,
                    op_ack, op_broadcast, op_remote, send_valid, send_id, out_len,
                    out_payload,
                    input ready);
    modport sink   (input valid, status, to_application, op_register, op_priority,
                    op_ack, op_broadcast, op_remote, send_valid, send_id, out_len,
                    out_payload,
                    output ready);
endinterface

// ===== rtl/can_register_node_handler.sv =====
// ============================================================================
// CAN register node handler
// Handles register 0 of a node's CAN register protocol and forwards the rest.
// ============================================================================
// Received 29-bit extended frames enter on the frame channel, one word per
// frame. Each frame gives exactly one result word on the result channel:
// a status, the decoded identifier fields, and either a frame to transmit
// (device id reply or address acknowledge) or the frame forwarded to the
// application.
// A frame is held in an input register, evaluated by flat logic against the
// live node address, and captured in the result register. One frame per
// cycle is sustained while the receiver keeps result.ready high; the node
// address update of a frame is seen by the next one.
// Configuration is written via cfg_write, cfg_index and cfg_data by the user,
// only while no frame is in flight (the block does not enforce it); a write to
// the initial address also loads the live node address unless it is broadcast.
// Reset clears all configuration, the node address and both valid flags.
// When the receiver stalls the result register holds its word, the input
// register fills, and frame.ready drops until the result is taken.
// ============================================================================
`include "can_register_node_handler_macros.svh"

module can_register_node_handler (
    input  logic                          clk,
    input  logic                          rst_n,
    cnh_frame_if.sink                     frame,
    cnh_result_if.source                  result,
    input  logic                          cfg_write,
    input  logic [cnh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cnh_pkg::CFG_W-1:0]     cfg_data
);
    import cnh_pkg::*;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    cnh_frame_t    s1_frame_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    cnh_result_t   result_reg;
    logic          advance;
    logic          take_frame;
    cnh_cfg_t      cfg;
    cnh_result_t   eval_res;
    cnh_addr_upd_t eval_upd;
    cnh_addr_upd_t addr_upd;
    logic          out_mismatch;
    logic          out_sends;
    logic          out_fwd;
    logic          out_blocked;
    logic          upd_only;

    assign advance     = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || advance;
    assign take_frame  = frame.valid && frame.ready;

    assign addr_upd.load = eval_upd.load && advance;
    assign addr_upd.addr = eval_upd.addr;

    cnh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .addr_upd  (addr_upd),
        .cfg       (cfg)
    );

    cnh_eval u_eval (
        .frame (s1_frame_reg),
        .cfg   (cfg),
        .res   (eval_res),
        .upd   (eval_upd)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (frame.ready)
        begin
            s1_valid_next = frame.valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_frame)
        begin
            s1_frame_reg.frame_id       <= frame.frame_id;
            s1_frame_reg.remote_request <= frame.remote_request;
            s1_frame_reg.payload_len    <= frame.payload_len;
            s1_frame_reg.payload        <= frame.payload;
        end
        if (advance)
        begin
            result_reg <= eval_res;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.status         = result_reg.status;
    assign result.to_application = result_reg.to_application;
    assign result.op_register    = result_reg.op_register;
    assign result.op_priority    = result_reg.op_priority;
    assign result.op_ack         = result_reg.op_ack;
    assign result.op_broadcast   = result_reg.op_broadcast;
    assign result.op_remote      = result_reg.op_remote;
    assign result.send_valid     = result_reg.send_valid;
    assign result.send_id        = result_reg.send_id;
    assign result.out_len        = result_reg.out_len;
    assign result.out_payload    = result_reg.out_payload;

    assign out_mismatch = out_valid_reg && (result_reg.status == STATUS_MISMATCH);
    assign out_sends    = result_reg.send_valid;
    assign out_fwd      = result_reg.to_application;
    assign out_blocked  = out_valid_reg && !result.ready;
    assign upd_only     = addr_upd.load && !cfg_write;

    `CNH_ASSERT_SAME(a_mismatch_quiet, clk, rst_n, out_mismatch, !out_sends && !out_fwd)
    `CNH_ASSERT_SAME(a_send_or_forward, clk, rst_n, out_valid_reg, !(out_sends && out_fwd))
    `CNH_ASSERT_NEXT(a_addr_loaded, clk, rst_n, upd_only, cfg.node_address == $past(addr_upd.addr))
    `CNH_ASSERT_SAME(a_full_stall, clk, rst_n, s1_valid_reg && out_blocked, !frame.ready)

endmodule

// ===== rtl/cnh_cfg_regs.sv =====
// ============================================================================
// CAN register node handler configuration
// Holds the configuration registers and the live node address.
// ============================================================================
module cnh_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [cnh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cnh_pkg::CFG_W-1:0]     cfg_data,
    input  cnh_pkg::cnh_addr_upd_t        addr_upd,
    output cnh_pkg::cnh_cfg_t             cfg
);
    import cnh_pkg::*;

    logic [NODE_W-1:0] node_address_reg;
    logic [7:0]        device_type_reg;
    logic [7:0]        upgrade_caps_reg;
    logic [15:0]       firmware_version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_address_reg     <= '0;
            device_type_reg      <= '0;
            upgrade_caps_reg     <= '0;
            firmware_version_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_INITIAL_ADDRESS:
                begin
                    // The broadcast value never becomes the live address.
                    if (cfg_data != BCAST_NODE)
                    begin
                        node_address_reg <= cfg_data;
                    end
                end
                CFG_DEVICE_TYPE:      device_type_reg      <= cfg_data[7:0];
                CFG_UPGRADE_CAPS:     upgrade_caps_reg     <= cfg_data[7:0];
                CFG_FIRMWARE_VERSION: firmware_version_reg <= cfg_data;
                default:              ;
            endcase
        end
        else if (addr_upd.load)
        begin
            node_address_reg <= addr_upd.addr;
        end
    end

    assign cfg.node_address     = node_address_reg;
    assign cfg.device_type      = device_type_reg;
    assign cfg.upgrade_caps     = upgrade_caps_reg;
    assign cfg.firmware_version = firmware_version_reg;

endmodule

// ===== rtl/cnh_eval.sv =====
// ============================================================================
// CAN register node handler frame evaluation
// Decodes one frame and forms its result and any node address change.
// ============================================================================
module cnh_eval (
    input  cnh_pkg::cnh_frame_t    frame,
    input  cnh_pkg::cnh_cfg_t      cfg,
    output cnh_pkg::cnh_result_t   res,
    output cnh_pkg::cnh_addr_upd_t upd
);
    import cnh_pkg::*;

    logic [NODE_W-1:0] node_id;
    logic [REG_W-1:0]  reg_num;
    logic              ack;
    logic              prio;
    logic              bcast;
    logic [NODE_W-1:0] new_addr;

    assign node_id  = frame.frame_id[ID_NODE_MSB:ID_NODE_LSB];
    assign reg_num  = frame.frame_id[REG_W-1:0];
    assign ack      = frame.frame_id[ID_ACK_BIT];
    assign prio     = frame.frame_id[ID_PRIO_BIT];
    assign bcast    = (node_id == BCAST_NODE);
    assign new_addr = frame.payload[DATA_W-1:DATA_W-NODE_W];

    always_comb
    begin
        res = '0;
        upd = '0;
        res.op_register  = reg_num;
        res.op_priority  = prio;
        res.op_ack       = ack;
        res.op_broadcast = bcast;
        res.op_remote    = frame.remote_request;

        if ((node_id != cfg.node_address) && !bcast)
        begin
            res.status = STATUS_MISMATCH;
        end
        else if (reg_num != REG_DEVICE_ID)
        begin
            res.to_application = 1'b1;
            res.out_len        = frame.payload_len;
            res.out_payload    = frame.payload;
        end
        else if (ack)
        begin
            res.status = STATUS_OK;
        end
        else if (bcast || frame.remote_request)
        begin
            res.send_valid  = 1'b1;
            res.send_id     = {1'b0, 1'b0, cfg.node_address, REG_DEVICE_ID};
            res.out_len     = REPLY_LEN;
            res.out_payload = {cfg.node_address, PROTO_VERSION, cfg.device_type,
                               cfg.upgrade_caps, cfg.firmware_version, 8'h00};
        end
        else if (frame.payload_len < MIN_WRITE_LEN)
        begin
            res.status = STATUS_SHORT;
        end
        else if (new_addr == BCAST_NODE)
        begin
            res.status = STATUS_BCAST_REF;
        end
        else
        begin
            upd.load       = 1'b1;
            upd.addr       = new_addr;
            res.send_valid = 1'b1;
            res.send_id    = {prio, 1'b1, new_addr, reg_num};
            res.out_len    = ACK_LEN;
        end
    end

endmodule

// ===== test/testbench.sv =====
// ============================================================================
// CAN register node handler testbench
// Sends received frames through the valid/ready frame channel, predicts the
// result word of each accepted frame from a behavioral model of the node
// (live address, device id reply, address write and acknowledge, forwarding)
// and compares every result word field by field. Both channels idle at
// random, and the configuration is rewritten between phases.
// ============================================================================
module testbench;
    import cnh_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 310;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cnh_frame_if  frm ();
    cnh_result_if res ();

    can_register_node_handler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frm),
        .result    (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [NODE_W-1:0] live_addr;
    logic [7:0]        dev_type;
    logic [7:0]        upg_caps;
    logic [15:0]       fw_version;

    cnh_result_t awaited_results[$];
    int          mismatches  = 0;
    int          idle_cycles = 0;
    bit          steady      = 1'b0;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic cnh_frame_t make_frame(input logic [NODE_W-1:0] node,
                                              input logic [REG_W-1:0] rg,
                                              input logic ack,
                                              input logic prio,
                                              input logic rtr,
                                              input logic [LEN_W-1:0] len,
                                              input logic [DATA_W-1:0] data);
        cnh_frame_t f;
        f.frame_id       = {prio, ack, node, rg};
        f.remote_request = rtr;
        f.payload_len    = len;
        f.payload        = data;
        return f;
    endfunction

    // Computes the result word of one frame and applies its address update.
    function automatic cnh_result_t node_response(input cnh_frame_t f);
        cnh_result_t       r;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] new_addr;
        r             = '0;
        node          = f.frame_id[ID_NODE_MSB:ID_NODE_LSB];
        r.op_register = f.frame_id[REG_W-1:0];
        r.op_priority = f.frame_id[ID_PRIO_BIT];
        r.op_ack      = f.frame_id[ID_ACK_BIT];
        r.op_broadcast = (node == BCAST_NODE);
        r.op_remote   = f.remote_request;
        if (node != live_addr && !r.op_broadcast)
        begin
            r.status = STATUS_MISMATCH;
        end
        else if (r.op_register != REG_DEVICE_ID)
        begin
            r.to_application = 1'b1;
            r.out_len        = f.payload_len;
            r.out_payload    = f.payload;
        end
        else if (!r.op_ack)
        begin
            if (r.op_broadcast || f.remote_request)
            begin
                r.send_valid  = 1'b1;
                r.send_id     = {1'b0, 1'b0, live_addr, REG_DEVICE_ID};
                r.out_len     = REPLY_LEN;
                r.out_payload = {live_addr, PROTO_VERSION, dev_type, upg_caps,
                                 fw_version, 8'h00};
            end
            else if (f.payload_len < MIN_WRITE_LEN)
            begin
                r.status = STATUS_SHORT;
            end
            else
            begin
                new_addr = f.payload[63:48];
                if (new_addr == BCAST_NODE)
                begin
                    r.status = STATUS_BCAST_REF;
                end
                else
                begin
                    live_addr    = new_addr;
                    r.send_valid = 1'b1;
                    r.send_id    = {r.op_priority, 1'b1, new_addr, REG_DEVICE_ID};
                    r.out_len    = ACK_LEN;
                end
            end
        end
        return r;
    endfunction

    function automatic cnh_frame_t random_frame();
        logic [NODE_W-1:0] node;
        logic [REG_W-1:0]  rg;
        logic [DATA_W-1:0] data;
        logic [LEN_W-1:0]  len;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: node = live_addr;
            4, 5:       node = BCAST_NODE;
            6:          node = live_addr ^ (16'h1 << $urandom_range(0, 15));
            default:    node = NODE_W'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: rg = REG_DEVICE_ID;
            5:             rg = 11'h7FF;
            default:       rg = REG_W'($urandom);
        endcase
        data = {$urandom, $urandom};
        if ($urandom_range(0, 7) == 0)
            data[63:48] = BCAST_NODE;
        len = LEN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                 : $urandom_range(0, 8));
        return make_frame(node, rg, $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)),
                          $urandom_range(0, 3) == 0, len, data);
    endfunction

    task automatic send_frame(input cnh_frame_t f);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        repeat (gap)
        begin
            frm.valid <= 1'b0;
            @(negedge clk);
        end
        frm.valid          <= 1'b1;
        frm.frame_id       <= f.frame_id;
        frm.remote_request <= f.remote_request;
        frm.payload_len    <= f.payload_len;
        frm.payload        <= f.payload;
        do
            @(posedge clk);
        while (!frm.ready);
        awaited_results.push_back(node_response(f));
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        frm.valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_INITIAL_ADDRESS:
            begin
                if (value != BCAST_NODE)
                    live_addr = value;
            end
            CFG_DEVICE_TYPE:      dev_type   = value[7:0];
            CFG_UPGRADE_CAPS:     upg_caps   = value[7:0];
            CFG_FIRMWARE_VERSION: fw_version = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_config(input logic [15:0] addr, input logic [7:0] dtype,
                              input logic [7:0] caps, input logic [15:0] version);
        wait_until_drained();
        write_reg(CFG_INITIAL_ADDRESS, addr);
        write_reg(CFG_DEVICE_TYPE, {8'h00, dtype});
        write_reg(CFG_UPGRADE_CAPS, {8'h00, caps});
        write_reg(CFG_FIRMWARE_VERSION, version);
    endtask

    task automatic test_reset_state();
        send_frame(make_frame(16'h0000, REG_DEVICE_ID, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0));
        send_frame(make_frame(16'h0000, 11'h005, 1'b0, 1'b0, 1'b0, 4'd3, 64'h0123456789ABCDEF));
        send_frame(make_frame(16'h0001, REG_DEVICE_ID, 1'b0, 1'b0, 1'b1, 4'd8, 64'h0));
    endtask

    task automatic test_device_id();
        set_config(16'hFFFE, 8'hFF, 8'hFF, 16'hFFFF);
        send_frame(make_frame(BCAST_NODE, REG_DEVICE_ID, 1'b0, 1'b1, 1'b0, 4'd0, 64'h0));
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b1, 1'b1, 4'd0, 64'h0));
        send_frame(make_frame(BCAST_NODE, REG_DEVICE_ID, 1'b1, 1'b0, 1'b1, 4'd8, '1));
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b1, 1'b1, 1'b0, 4'd2,
                              64'h1234000000000000));
        send_frame(make_frame(BCAST_NODE, REG_DEVICE_ID, 1'b0, 1'b0, 1'b0, 4'd8,
                              64'h4321000000000000));
        send_frame(make_frame(16'h7FFF, REG_DEVICE_ID, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0));
    endtask

    task automatic test_address_write();
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b0, 1'b0, 4'd1,
                              64'h1234000000000000));
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b1, 1'b0, 4'd2,
                              64'hFFFF000000000000));
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b0, 1'b0, 4'd2,
                              64'h0000FFFFFFFFFFFF));
        send_frame(make_frame(16'hFFFE, 11'h003, 1'b0, 1'b0, 1'b0, 4'd2, 64'h0));
        wait_until_drained();
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b1, 1'b0, 4'd15,
                              64'hFFFE5A5A5A5A5A5A));
        send_frame(make_frame(16'hFFFE, REG_DEVICE_ID, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0));
    endtask

    task automatic test_forwarding();
        send_frame(make_frame(live_addr, 11'h7FF, 1'b1, 1'b1, 1'b1, 4'd15, '1));
        send_frame(make_frame(live_addr, 11'h001, 1'b0, 1'b0, 1'b0, 4'd0, 64'h0));
        send_frame(make_frame(BCAST_NODE, 11'h400, 1'b0, 1'b1, 1'b0, 4'd9,
                              64'hA5A5A5A5A5A5A5A5));
    endtask

    task automatic test_broadcast_initial();
        wait_until_drained();
        write_reg(CFG_INITIAL_ADDRESS, BCAST_NODE);
        send_frame(make_frame(live_addr, REG_DEVICE_ID, 1'b0, 1'b0, 1'b1, 4'd0, 64'h0));
        send_frame(make_frame(live_addr, 11'h010, 1'b0, 1'b0, 1'b0, 4'd4, 64'h0));
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       set_config(16'h0000, 8'h00, 8'h00, 16'h0000);
                1:       set_config(16'hFFFE, 8'hFF, 8'hFF, 16'hFFFF);
                default: set_config(16'($urandom_range(0, 16'hFFFE)),
                                    8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)),
                                    16'($urandom_range(0, 16'hFFFF)));
            endcase
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (i % 40 == 0)
                    steady = ($urandom_range(0, 3) == 0);
                send_frame(random_frame());
            end
        end
        steady = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
        if (seen !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, seen);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        cnh_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result word expected none, got status %0h register %0h",
                         $time, res.status, res.op_register);
            end
            else
            begin
                want = awaited_results.pop_front();
                check_field("status", 64'(want.status), 64'(res.status));
                check_field("to_application", 64'(want.to_application),
                            64'(res.to_application));
                check_field("op_register", 64'(want.op_register), 64'(res.op_register));
                check_field("op_priority", 64'(want.op_priority), 64'(res.op_priority));
                check_field("op_ack", 64'(want.op_ack), 64'(res.op_ack));
                check_field("op_broadcast", 64'(want.op_broadcast), 64'(res.op_broadcast));
                check_field("op_remote", 64'(want.op_remote), 64'(res.op_remote));
                check_field("send_valid", 64'(want.send_valid), 64'(res.send_valid));
                check_field("send_id", 64'(want.send_id), 64'(res.send_id));
                check_field("out_len", 64'(want.out_len), 64'(res.out_len));
                check_field("out_payload", want.out_payload, res.out_payload);
            end
        end
    end

    initial
    begin : result_ready
        int unsigned stall;
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 8);
            @(negedge clk);
            repeat (stall)
            begin
                res.ready <= 1'b0;
                @(negedge clk);
            end
            res.ready <= 1'b1;
            do
                @(posedge clk);
            while (!res.valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (frm.valid && frm.ready) || (res.valid && res.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("can_register_node_handler test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = CFG_INITIAL_ADDRESS;
        cfg_data           = '0;
        frm.valid          = 1'b0;
        frm.frame_id       = '0;
        frm.remote_request = 1'b0;
        frm.payload_len    = '0;
        frm.payload        = '0;
        live_addr          = '0;
        dev_type           = '0;
        upg_caps           = '0;
        fw_version         = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_device_id();
        test_address_write();
        test_forwarding();
        test_broadcast_initial();
        test_random_traffic();

        wait_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("can_register_node_handler test passed");
        else
            $display("can_register_node_handler test failed");
        $finish;
    end
endmodule
